// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the sorter controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, masked while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true on a rising clk edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/oets_pkg.sv =====
// Shared types for the odd-even transposition sorter.
package oets_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	// Commands from the controller to the cell row.
	typedef struct packed {
		logic load;       // shift a new element into cell 0
		logic unload;     // shift all cells toward cell 0
		logic sort;       // run one compare-exchange phase
		logic phase_odd;  // 0: pairs (0,1),(2,3)..; 1: pairs (1,2),(3,4)..
	} dp_cmd_t;

endpackage

// ===== rtl/core/oets_ctrl.sv =====
// Sequencer for the sorter: load, sort rounds, emit.
`include "assert_macros.svh"

module oets_ctrl
	import oets_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          last_in,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          last_out,
	output logic          overflow,
	output logic [CW-1:0] count,
	output dp_cmd_t       cmd
);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] round_q, round_d;
	logic          phase_q, phase_d;
	logic          ovf_q, ovf_d;
	logic          in_acc, out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			round_q <= '0;
			phase_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			round_q <= round_d;
			phase_q <= phase_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		round_d   = round_q;
		phase_d   = phase_q;
		ovf_d     = ovf_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		in_acc    = 1'b0;
		out_acc   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				in_acc   = in_valid;
				if (in_acc) begin
					if (count_q < CW'(DEPTH)) begin
						cmd.load = 1'b1;
						count_d  = count_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last_in) begin
						state_d = ST_SORT;
						round_d = '0;
						phase_d = 1'b0;
					end
				end
			end
			ST_SORT: begin
				cmd.sort      = 1'b1;
				cmd.phase_odd = phase_q;
				phase_d       = ~phase_q;
				if (phase_q) begin
					round_d = round_q + CW'(1);
					if (round_q == count_q - CW'(1)) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				out_acc   = ~out_stall;
				if (out_acc) begin
					cmd.unload = 1'b1;
					count_d    = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						state_d = ST_LOAD;
						ovf_d   = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign last_out = (count_q == CW'(1));
	assign overflow = ovf_q;
	assign count    = count_q;

	`ASSERT_NEVER(a_no_in_while_emit, out_valid && !in_stall, "input open during emit")
	`ASSERT_NEVER(a_count_range, count_q > CW'(DEPTH), "element count beyond depth")
	`ASSERT_CLK(a_last_in_sorts, in_acc && last_in |=> state_q == ST_SORT,
		"closing element did not start sort")
	`ASSERT_CLK(a_last_out_clears, out_acc && last_out |=> count_q == '0 && !ovf_q,
		"block state not cleared after final result")
	`ASSERT_NEVER(a_empty_emit, state_q == ST_EMIT && count_q == '0, "emit with no elements")

endmodule

// ===== rtl/core/oets_dpath.sv =====
// Row of element cells with parallel compare-exchange between neighbors.
module oets_dpath
	import oets_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  dp_cmd_t                  cmd,
	input  logic        [CW-1:0]     count,
	input  logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] sorted_value
);

	logic signed [DATA_W-1:0] elem_q [DEPTH];
	logic signed [DATA_W-1:0] swap_d [DEPTH];

	// One phase: disjoint pairs, only those fully inside the block.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			swap_d[i] = elem_q[i];
		end
		for (int j = 1; j < DEPTH; j++) begin
			if ((j[0] != cmd.phase_odd) && (CW'(j) < count)) begin
				if (elem_q[j-1] > elem_q[j]) begin
					swap_d[j-1] = elem_q[j];
					swap_d[j]   = elem_q[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.load) begin
				elem_q[i] <= (i == 0) ? value : elem_q[(i == 0) ? 0 : i - 1];
			end else if (cmd.unload) begin
				elem_q[i] <= (i == DEPTH - 1) ? elem_q[i] : elem_q[(i == DEPTH - 1) ? i : i + 1];
			end else if (cmd.sort) begin
				elem_q[i] <= swap_d[i];
			end
		end
	end

	assign sorted_value = elem_q[0];

endmodule

// ===== rtl/core/odd_even_transposition_sort_top.sv =====
// Top level of the odd-even transposition sorter.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_stall   | value, last_in
//  out     | out_valid / out_stall | sorted_value, last_out, overflow
//
// A block of n elements is loaded one transaction per cycle, then sorted
// in n rounds of an even and an odd phase, one phase per cycle through the
// single row of compare-exchange cells, then emitted as n results.
// Input stays stalled from the closing element until the final result
// of the block is taken; out_stall freezes the emit with payload held.
// Reset clears the controller only; no clearing pass is needed.
module odd_even_transposition_sort_top
	import oets_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     last_out,
	output logic                     overflow
);

	localparam int CW = $clog2(DEPTH + 1);

	dp_cmd_t       cmd;
	logic [CW-1:0] count;

	// Sequencer: element count, round/phase counter, overflow flag.
	oets_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_out  (last_out),
		.overflow  (overflow),
		.count     (count),
		.cmd       (cmd)
	);

	// Element cells: shift in on load, sort in place, shift out from cell 0.
	oets_dpath #(.DEPTH(DEPTH)) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.count        (count),
		.value        (value),
		.sorted_value (sorted_value)
	);

endmodule

// ===== bench/tb_odd_even_transposition_sort_top.sv =====
// Self-checking bench for the odd-even transposition sorter: random blocks, stalls, predicted order.
module tb_odd_even_transposition_sort_top;
	import oets_pkg::*;

	localparam int DEPTH      = 16;
	localparam int IDLE_LIMIT = 2000;  // cycles with no transaction on either channel
	localparam int HOLD_LEN   = 300;   // long receiver hold-off in mid-emit, keeps the input stalled
	localparam int SETTLE     = 80;    // quiet cycles after the last expected result
	localparam int RANDOM_N   = 146;   // elements in the random part, at least

	localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] V_MAX = ~V_MIN;

	// One input transaction.
	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} element_t;

	// One output transaction.
	typedef struct {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_out;
		logic                     overflow;
	} sorted_t;

	// All DUT inputs start at known values.
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     last_in   = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last_out;
	logic                     overflow;

	odd_even_transposition_sort_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sorted_value(sorted_value),
		.last_out    (last_out),
		.overflow    (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Handshake qualifiers; an X stall from the DUT never counts as a transfer.
	wire in_take  = (in_valid === 1'b1) && (in_stall === 1'b0);
	wire out_take = (out_valid === 1'b1) && (out_stall === 1'b0);

	// ------------------------------------------------------------------
	// Predictor: mirror of the element store, count and drop flag.
	// ------------------------------------------------------------------
	logic signed [DATA_W-1:0] blk_store [DEPTH];
	int unsigned              blk_count   = 0;
	logic                     blk_dropped = 1'b0;
	sorted_t                  pending_sorted [$];  // expected results, oldest first

	// Store (or drop) one element; a last mark sorts the block and queues its results.
	task automatic absorb_element(input element_t e);
		logic signed [DATA_W-1:0] t;
		sorted_t                  r;
		int unsigned              n;
		if (blk_count < DEPTH) begin
			blk_store[blk_count] = e.value;
			blk_count++;
		end else begin
			blk_dropped = 1'b1;  // no room: element lost, even a closing one
		end
		if (e.last) begin
			n = blk_count;
			// n rounds; phase 0 pairs (0,1),(2,3)..; phase 1 pairs (1,2),(3,4)..
			// Swap only when strictly out of order, so equal values stay put.
			for (int rnd = 0; rnd < n; rnd++) begin
				for (int ph = 0; ph < 2; ph++) begin
					for (int j = 1 + ph; j < n; j += 2) begin
						if (blk_store[j-1] > blk_store[j]) begin
							t              = blk_store[j-1];
							blk_store[j-1] = blk_store[j];
							blk_store[j]   = t;
						end
					end
				end
			end
			for (int k = 0; k < n; k++) begin
				r.sorted_value = blk_store[k];
				r.last_out     = (k + 1 == n);
				r.overflow     = blk_dropped;
				pending_sorted.push_back(r);
			end
			blk_count   = 0;
			blk_dropped = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	int errors = 0;

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge.
	// ------------------------------------------------------------------
	int unsigned accept_count = 0;  // all transactions, feeds the watchdog
	int unsigned results_seen = 0;
	logic        in_fire      = 1'b0;  // input transaction at the last rising edge
	sorted_t     want_res;

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_take;
			if (in_take) begin
				absorb_element(element_t'{value, last_in});
				accept_count++;
			end
			if (out_take) begin
				accept_count++;
				results_seen++;
				if (pending_sorted.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected", sorted_value));
				end else begin
					want_res = pending_sorted.pop_front();
					if (sorted_value !== want_res.sorted_value)
						report_mismatch($sformatf("sorted_value %0d, expected %0d",
							sorted_value, want_res.sorted_value));
					if (last_out !== want_res.last_out)
						report_mismatch($sformatf("last_out %b, expected %b",
							last_out, want_res.last_out));
					if (overflow !== want_res.overflow)
						report_mismatch($sformatf("overflow %b, expected %b",
							overflow, want_res.overflow));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Idle gaps: mostly none, some short, a few long; calm stretches have none.
	// ------------------------------------------------------------------
	function automatic int idle_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driver: feeds element_q at the falling edge, holds payload while stalled.
	// ------------------------------------------------------------------
	element_t element_q [$];
	element_t cur_elem;
	int       gap_left = 0;
	int       tx_calm  = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (tx_calm > 0)
				tx_calm--;
			else if ($urandom_range(0, 59) == 0)
				tx_calm = $urandom_range(20, 60);
			// Move on only once the offered transaction went through (or none was offered).
			if (!in_valid || in_fire) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (element_q.size() != 0) begin
					cur_elem = element_q.pop_front();
					in_valid <= 1'b1;
					value    <= cur_elem.value;
					last_in  <= cur_elem.last;
					gap_left = idle_gap(tx_calm > 0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls plus long hold-offs in mid-emit. During a hold
	// the sender keeps offering, and the input stays stalled until the block is emitted.
	// ------------------------------------------------------------------
	int          stall_left   = 0;
	int          hold_left    = 0;
	int          rx_calm      = 0;
	int          holds_done   = 0;
	int unsigned next_hold_at = 30;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_calm > 0)
				rx_calm--;
			else if ($urandom_range(0, 59) == 0)
				rx_calm = $urandom_range(20, 60);
			if (hold_left == 0 && holds_done < 2 && out_valid === 1'b1 &&
			    results_seen >= next_hold_at) begin
				hold_left    = HOLD_LEN;
				holds_done++;
				next_hold_at += 120;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_gap(rx_calm > 0);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any transaction ends the run.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int unsigned seen;
		int unsigned idle;
		seen = 0;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(negedge clk);
			if (accept_count != seen) begin
				seen = accept_count;
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
		$display("tb_odd_even_transposition_sort_top: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int unsigned              blocks_sent     = 0;
	int unsigned              overflow_blocks = 0;
	int unsigned              elements_sent   = 0;
	logic signed [DATA_W-1:0] prev_value      = '0;

	task automatic queue_element(input logic signed [DATA_W-1:0] v, input logic last);
		element_q.push_back(element_t'{v, last});
		elements_sent++;
		if (last)
			blocks_sent++;
	endtask

	// Extremes, tiny values around zero and repeats, so ties are common.
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = V_MIN;
			1:       v = V_MAX;
			2:       v = prev_value;
			3, 4:    v = $signed($urandom_range(0, 15)) - 8;
			default: v = $urandom();
		endcase
		prev_value = v;
		return v;
	endfunction

	initial begin
		int len;
		int pick;

		// Directed: single-element block at the minimum.
		queue_element(V_MIN, 1'b1);
		// Extremes, zero, minus one and a tie inside one block.
		queue_element(V_MAX, 1'b0);
		queue_element(V_MIN, 1'b0);
		queue_element(0, 1'b0);
		queue_element(-1, 1'b0);
		queue_element(0, 1'b0);
		queue_element(1, 1'b1);
		// Too long: a full store in descending order, then the closing element is dropped.
		for (int i = 0; i < DEPTH; i++)
			queue_element(DEPTH - 1 - i, 1'b0);
		queue_element(V_MAX, 1'b1);
		overflow_blocks++;

		// Random blocks: mostly short, some up to the full store, a few overflowing.
		while (elements_sent < 24 + RANDOM_N) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				len = $urandom_range(1, 6);
			else if (pick < 88)
				len = $urandom_range(7, DEPTH);
			else
				len = $urandom_range(DEPTH + 1, DEPTH + 4);
			if (len > DEPTH)
				overflow_blocks++;
			for (int i = 0; i < len; i++)
				queue_element(pick_value(), i == len - 1);
		end

		// Single reset at the start of the run.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: every element taken, every result seen, then a quiet stretch.
		while (element_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_sorted.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_sorted.size()));

		$display("covered %0d blocks (%0d over capacity), %0d elements in, %0d results out",
			blocks_sent, overflow_blocks, elements_sent, results_seen);
		$display("receiver long hold-offs: %0d, mismatches: %0d", holds_done, errors);
		if (errors == 0)
			$display("tb_odd_even_transposition_sort_top: done, clean");
		else
			$display("tb_odd_even_transposition_sort_top: done, errors");
		$finish;
	end

endmodule
